>>> rtl/assert_macros.svh
// assertion helpers used by afc_resolve
// each use sits inside a module that has clk and arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define AFC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define AFC_ASSERT_NEXT(lbl, ante, cons) \
	`AFC_ASSERT(lbl, (ante) |=> (cons))

`endif

>>> rtl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants of the box-versus-frustum classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package afc_pkg;

	localparam int COORD_BITS = 16;
	localparam int NUM_PLANES = 6;
	localparam int COEF_BITS  = 16;
	localparam int FRAC_BITS  = 14;
	localparam int IDX_W      = 3;
	localparam int PROD_W     = COEF_BITS + COORD_BITS;
	localparam int OFFS_W     = COEF_BITS + FRAC_BITS;
	localparam int DIST_W     = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COEF_BITS-1:0]  coef_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [DIST_W-1:0]     dist_t;

	typedef enum logic [1:0] {
		VERD_INSIDE  = 2'd0,
		VERD_ISECT   = 2'd1,
		VERD_OUTSIDE = 2'd2
	} verdict_t;

	typedef enum logic [IDX_W-1:0] {
		REG_PLANE_LEFT   = 3'd0,
		REG_PLANE_RIGHT  = 3'd1,
		REG_PLANE_BOTTOM = 3'd2,
		REG_PLANE_TOP    = 3'd3,
		REG_PLANE_NEAR   = 3'd4,
		REG_PLANE_FAR    = 3'd5
	} reg_idx_t;

	// register packing, d in the top 16 bits
	typedef struct packed {
		coef_t d;
		coef_t nz;
		coef_t ny;
		coef_t nx;
	} plane_t;

	// request travelling down the cell chain
	typedef struct packed {
		coord_t [2:0]                  lo;
		coord_t [2:0]                  hi;
		logic   [NUM_PLANES-1:0]       mask;
		logic   [IDX_W-1:0]            start;
		logic   [NUM_PLANES-1:0][1:0]  res;
	} box_t;

endpackage

`default_nettype wire

>>> rtl/aabb_frustum_classify.sv
// a request passes through the six plane cells and then the resolve output register before out_valid
// throughput: one request per cycle while the output is not stalled, six plane cells of two stages each
// a stalled output holds the whole chain in place
// reset clears all six plane registers to zero and empties the chain
// ----------------------------------------------------------------------------
// aabb_frustum_classify
// Classifies an axis-aligned box against six configured frustum planes as
// inside, intersecting or outside, with plane masking and a start plane.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_frustum_classify
	import afc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [IDX_W-1:0]      cfg_index,
	input  wire logic [63:0]           cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire coord_t                min_x,
	input  wire coord_t                min_y,
	input  wire coord_t                min_z,
	input  wire coord_t                max_x,
	input  wire coord_t                max_y,
	input  wire coord_t                max_z,
	input  wire logic [NUM_PLANES-1:0] mask_in,
	input  wire logic [IDX_W-1:0]      start_in,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 verdict,
	output logic [NUM_PLANES-1:0]      mask_out,
	output logic [IDX_W-1:0]           start_out
);

	plane_t plane_q [NUM_PLANES];
	logic   adv;
	logic   chain_vld [NUM_PLANES+1];
	box_t   chain [NUM_PLANES+1];

	assign cfg_ready = 1'b1;
	assign in_ready  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_index <= REG_PLANE_FAR) begin
			plane_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		chain_vld[0]   = in_valid;
		chain[0].lo    = {min_z, min_y, min_x};
		chain[0].hi    = {max_z, max_y, max_x};
		chain[0].mask  = mask_in;
		chain[0].start = start_in;
		chain[0].res   = '0;
	end

	for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
		afc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.plane  (plane_q[g]),
			.vld_i  (chain_vld[g]),
			.box_i  (chain[g]),
			.vld_o  (chain_vld[g+1]),
			.box_o  (chain[g+1])
		);
	end

	afc_resolve u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_i     (chain_vld[NUM_PLANES]),
		.box_i     (chain[NUM_PLANES]),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict),
		.mask_out  (mask_out),
		.start_out (start_out)
	);

endmodule

`default_nettype wire

>>> rtl/afc_cell.sv
// ----------------------------------------------------------------------------
// afc_cell
// One plane test: corner products in the first stage, distances and the
// plane verdict in the second, shifted into the result field of the request.
// ----------------------------------------------------------------------------
`default_nettype none

module afc_cell
	import afc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   adv,
	input  wire plane_t plane,
	input  wire logic   vld_i,
	input  wire box_t   box_i,
	output logic        vld_o,
	output box_t        box_o
);

	coef_t  n [3];
	coord_t near_c [3];
	coord_t far_c [3];
	prod_t  pn [3];
	prod_t  pf [3];

	logic   vld_s1;
	box_t   box_s1;
	prod_t  pn_s1 [3];
	prod_t  pf_s1 [3];
	coef_t  d_s1;

	logic   vld_s2;
	box_t   box_s2;

	dist_t    dn;
	dist_t    df;
	verdict_t r;
	box_t     box_nx;

	assign n[0] = plane.nx;
	assign n[1] = plane.ny;
	assign n[2] = plane.nz;

	// near corner from min where the normal is non-negative
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			near_c[a] = n[a][COEF_BITS-1] ? box_i.hi[a] : box_i.lo[a];
			far_c[a]  = n[a][COEF_BITS-1] ? box_i.lo[a] : box_i.hi[a];
			pn[a]     = prod_t'(n[a]) * prod_t'(near_c[a]);
			pf[a]     = prod_t'(n[a]) * prod_t'(far_c[a]);
		end
	end

	always_comb begin
		dn = (dist_t'(d_s1) <<< FRAC_BITS) + dist_t'(pn_s1[0]) + dist_t'(pn_s1[1])
			+ dist_t'(pn_s1[2]);
		df = (dist_t'(d_s1) <<< FRAC_BITS) + dist_t'(pf_s1[0]) + dist_t'(pf_s1[1])
			+ dist_t'(pf_s1[2]);
		if (!dn[DIST_W-1] && dn != '0) begin
			r = VERD_OUTSIDE;
		end else if (!df[DIST_W-1]) begin
			r = VERD_ISECT;
		end else begin
			r = VERD_INSIDE;
		end
	end

	always_comb begin
		box_nx     = box_s1;
		box_nx.res = {r, box_s1.res[NUM_PLANES-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			box_s1 <= box_i;
			d_s1   <= plane.d;
			for (int a = 0; a < 3; a++) begin
				pn_s1[a] <= pn[a];
				pf_s1[a] <= pf[a];
			end
			box_s2 <= box_nx;
		end
	end

	assign vld_o = vld_s2;
	assign box_o = box_s2;

endmodule

`default_nettype wire

>>> rtl/afc_resolve.sv
// ----------------------------------------------------------------------------
// afc_resolve
// Applies the test order (start plane first, then ascending) to the plane
// verdicts and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module afc_resolve
	import afc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld_i,
	input  wire box_t              box_i,
	output logic                   adv,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             verdict,
	output logic [NUM_PLANES-1:0]  mask_out,
	output logic [IDX_W-1:0]       start_out
);

	verdict_t               verd;
	logic [NUM_PLANES-1:0]  mask;
	logic [IDX_W-1:0]       start;
	logic                   done;

	assign adv = !out_valid || out_ready;

	always_comb begin
		mask  = box_i.mask;
		verd  = VERD_INSIDE;
		start = box_i.start;
		done  = 1'b0;
		// start plane
		for (int i = 0; i < NUM_PLANES; i++) begin
			if (IDX_W'(i) == box_i.start && box_i.mask[i]) begin
				if (box_i.res[i] == VERD_OUTSIDE) begin
					verd = VERD_OUTSIDE;
					done = 1'b1;
				end else if (box_i.res[i] == VERD_ISECT) begin
					verd = VERD_ISECT;
				end else begin
					mask[i] = 1'b0;
				end
			end
		end
		// remaining planes in index order
		for (int i = 0; i < NUM_PLANES; i++) begin
			if (!done && IDX_W'(i) != box_i.start && box_i.mask[i]) begin
				if (box_i.res[i] == VERD_OUTSIDE) begin
					verd  = VERD_OUTSIDE;
					start = IDX_W'(i);
					done  = 1'b1;
				end else if (box_i.res[i] == VERD_ISECT) begin
					verd = VERD_ISECT;
				end else begin
					mask[i] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			verdict   <= verd;
			mask_out  <= mask;
			start_out <= start;
		end
	end

	`AFC_ASSERT(a_reject_plane_kept, out_valid && verdict == VERD_OUTSIDE |-> start_out < IDX_W'(NUM_PLANES) && mask_out[start_out])
	`AFC_ASSERT(a_inside_clears_all, out_valid && verdict == VERD_INSIDE |-> mask_out == '0)
	`AFC_ASSERT(a_isect_keeps_plane, out_valid && verdict == VERD_ISECT |-> mask_out != '0)

endmodule

`default_nettype wire

>>> test/tb_aabb_frustum_classify.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aabb_frustum_classify
// Drives box requests into the frustum classifier under several plane
// settings and traffic mixes, predicts each response with an in-bench plane
// test model and checks verdict, mask and start plane in arrival order.
// ----------------------------------------------------------------------------

module tb_aabb_frustum_classify;
	import afc_pkg::*;

	localparam int PIPE_LAT       = 13;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int UNIT_NORMAL    = 1 << FRAC_BITS;

	typedef struct packed {
		coord_t [2:0]          lo;
		coord_t [2:0]          hi;
		logic [NUM_PLANES-1:0] mask;
		logic [IDX_W-1:0]      start;
		logic                  hold;
	} aabb_req_t;

	typedef struct packed {
		verdict_t              verdict;
		logic [NUM_PLANES-1:0] mask;
		logic [IDX_W-1:0]      start;
	} aabb_class_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index;
	logic [63:0]           cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	coord_t                min_x, min_y, min_z, max_x, max_y, max_z;
	logic [NUM_PLANES-1:0] mask_in;
	logic [IDX_W-1:0]      start_in;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            verdict;
	logic [NUM_PLANES-1:0] mask_out;
	logic [IDX_W-1:0]      start_out;

	aabb_req_t   pending_boxes [$];
	aabb_class_t class_q [$];
	plane_t      plane_copy [NUM_PLANES];
	plane_t      cfg_next [NUM_PLANES];
	aabb_req_t   drv_box;
	aabb_req_t   mon_box;
	aabb_class_t want;
	logic        in_fire;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          n_queued       = 0;
	int          n_checked      = 0;
	int          n_errors       = 0;
	int          n_settings     = 0;
	int          stall_cycles   = 0;
	int          n_verd [3]     = '{0, 0, 0};

	aabb_frustum_classify uut (.*);

	always #4 clk = ~clk;

	// signed distance of the near and far corner against one plane
	function automatic verdict_t plane_test(plane_t p, aabb_req_t b);
		coef_t  nrm [3];
		longint near_d, far_d, n, lo, hi;
		int     a;
		nrm[0] = p.nx;
		nrm[1] = p.ny;
		nrm[2] = p.nz;
		near_d = longint'(signed'(p.d)) * longint'(UNIT_NORMAL);
		far_d  = near_d;
		for (a = 0; a < 3; a++) begin
			n  = longint'(signed'(nrm[a]));
			lo = longint'(signed'(b.lo[a]));
			hi = longint'(signed'(b.hi[a]));
			if (n >= 0) begin
				near_d += n * lo;
				far_d  += n * hi;
			end else begin
				near_d += n * hi;
				far_d  += n * lo;
			end
		end
		if (near_d > 0)
			return VERD_OUTSIDE;
		if (far_d >= 0)
			return VERD_ISECT;
		return VERD_INSIDE;
	endfunction

	function automatic aabb_class_t classify_box(aabb_req_t b);
		aabb_class_t           res;
		verdict_t              r;
		logic [NUM_PLANES-1:0] m;
		int                    st, i;
		bit                    rejected;
		m           = b.mask;
		st          = b.start;
		rejected    = 1'b0;
		res.verdict = VERD_INSIDE;
		if (st < NUM_PLANES && m[st]) begin
			r = plane_test(plane_copy[st], b);
			if (r == VERD_OUTSIDE) begin
				res.verdict = VERD_OUTSIDE;
				rejected    = 1'b1;
			end else if (r == VERD_ISECT) begin
				res.verdict = VERD_ISECT;
			end else begin
				m[st] = 1'b0;
			end
		end
		for (i = 0; i < NUM_PLANES; i++) begin
			if (!rejected && i != st && m[i]) begin
				r = plane_test(plane_copy[i], b);
				if (r == VERD_OUTSIDE) begin
					res.verdict = VERD_OUTSIDE;
					st          = i;
					rejected    = 1'b1;
				end else if (r == VERD_ISECT) begin
					res.verdict = VERD_ISECT;
				end else begin
					m[i] = 1'b0;
				end
			end
		end
		res.mask  = m;
		res.start = st[IDX_W-1:0];
		return res;
	endfunction

	function automatic aabb_req_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz,
			int m, int s);
		aabb_req_t b;
		b.lo[0] = coord_t'(lx);
		b.lo[1] = coord_t'(ly);
		b.lo[2] = coord_t'(lz);
		b.hi[0] = coord_t'(hx);
		b.hi[1] = coord_t'(hy);
		b.hi[2] = coord_t'(hz);
		b.mask  = NUM_PLANES'(m);
		b.start = IDX_W'(s);
		b.hold  = 1'b0;
		return b;
	endfunction

	// mostly boxes around the frustum, some full range, some with min above max
	function automatic aabb_req_t random_box();
		aabb_req_t b;
		coord_t    t;
		int        sel, a, c, e;
		sel = $urandom_range(99);
		for (a = 0; a < 3; a++) begin
			if (sel < 25) begin
				b.lo[a] = coord_t'($urandom);
				b.hi[a] = coord_t'($urandom);
			end else begin
				c = $urandom_range(3000);
				c = c - 1500;
				e = $urandom_range(600);
				b.lo[a] = coord_t'(c - e);
				b.hi[a] = coord_t'(c + e);
				if (sel >= 88) begin
					t       = b.lo[a];
					b.lo[a] = b.hi[a];
					b.hi[a] = t;
				end
			end
		end
		b.mask  = $urandom_range(1) ? {NUM_PLANES{1'b1}} : NUM_PLANES'($urandom_range(63));
		b.start = IDX_W'($urandom_range(7));
		b.hold  = ($urandom_range(59) == 0);
		return b;
	endfunction

	task automatic report(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		n_errors++;
	endtask

	task automatic push_box(input aabb_req_t b);
		pending_boxes.push_back(b);
		n_queued++;
	endtask

	task automatic queue_random(input int count);
		repeat (count) push_box(random_box());
	endtask

	task automatic wait_idle();
		while (n_checked != n_queued) @(negedge clk);
		repeat (PIPE_LAT + 2) @(negedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_planes();
		int i;
		for (i = 0; i < NUM_PLANES; i++)
			cfg_write(reg_idx_t'(i), cfg_next[i]);
		n_settings++;
		@(posedge clk);
	endtask

	// axis planes at +-half, off-axis normal components within +-tilt
	task automatic fill_frustum(input int half, input int tilt);
		int i, a;
		int comp [3];
		for (i = 0; i < NUM_PLANES; i++) begin
			for (a = 0; a < 3; a++) begin
				if (a == i / 2)
					comp[a] = (i % 2 == 0) ? -UNIT_NORMAL : UNIT_NORMAL;
				else if (tilt > 0)
					comp[a] = int'($urandom_range(2 * tilt)) - tilt;
				else
					comp[a] = 0;
			end
			cfg_next[i].nx = coef_t'(comp[0]);
			cfg_next[i].ny = coef_t'(comp[1]);
			cfg_next[i].nz = coef_t'(comp[2]);
			cfg_next[i].d  = coef_t'(-half);
		end
	endtask

	task automatic queue_directed();
		push_box(mk_box(-10, -10, -10, 10, 10, 10, 6'b111111, 0));
		push_box(mk_box(900, -10, -10, 1100, 10, 10, 6'b111111, 0));
		push_box(mk_box(2000, -10, -10, 3000, 10, 10, 6'b111111, 0));
		push_box(mk_box(2000, -10, -10, 3000, 10, 10, 6'b111111, 1));
		push_box(mk_box(2000, -10, -10, 3000, 10, 10, 6'b111111, 6));
		push_box(mk_box(-3000, -10, -10, -2000, 10, 10, 6'b111111, 7));
		push_box(mk_box(2000, -10, -10, 3000, 10, 10, 6'b111101, 1));
		push_box(mk_box(0, 0, 0, 0, 0, 0, 6'b000000, 3));
		push_box(mk_box(10, 10, 10, -10, -10, -10, 6'b111111, 2));
		push_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767, 6'b111111, 4));
		push_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767, 6'b111111, 0));
		push_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768, 6'b111111, 5));
		push_box(mk_box(-10, -10, 2000, 10, 10, 3000, 6'b111111, 0));
		push_box(mk_box(2000, -10, 2000, 3000, 10, 3000, 6'b111111, 5));
		push_box(mk_box(-10, -10, -10, 10, 10, 10, 6'b101010, 6));
		push_box(mk_box(-1000, -1000, -1000, 1000, 1000, 1000, 6'b111111, 0));
		push_box(mk_box(1001, 0, 0, 1001, 0, 0, 6'b111111, 0));
		push_box(mk_box(1000, 0, 0, 1000, 0, 0, 6'b111111, 2));
		push_box(mk_box(-999, -999, -999, 999, 999, 999, 6'b111111, 0));
		push_box(mk_box(500, -1500, 0, 600, -1200, 0, 6'b011111, 3));
	endtask

	// request driver, also drives out_ready
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (pending_boxes.size() != 0 && !(pending_boxes[0].hold && class_q.size() != 0)
					&& $urandom_range(99) >= send_idle_pct) begin
				drv_box = pending_boxes.pop_front();
				min_x    <= drv_box.lo[0];
				min_y    <= drv_box.lo[1];
				min_z    <= drv_box.lo[2];
				max_x    <= drv_box.hi[0];
				max_y    <= drv_box.hi[1];
				max_z    <= drv_box.hi[2];
				mask_in  <= drv_box.mask;
				start_in <= drv_box.start;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// predictor and response checker
	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (!arst_n) begin
			foreach (plane_copy[k])
				plane_copy[k] <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				plane_copy[cfg_index] <= plane_t'(cfg_data);
			if (in_valid && in_ready) begin
				mon_box.lo[0] = min_x;
				mon_box.lo[1] = min_y;
				mon_box.lo[2] = min_z;
				mon_box.hi[0] = max_x;
				mon_box.hi[1] = max_y;
				mon_box.hi[2] = max_z;
				mon_box.mask  = mask_in;
				mon_box.start = start_in;
				mon_box.hold  = 1'b0;
				class_q.push_back(classify_box(mon_box));
			end
			if (out_valid && out_ready) begin
				if (class_q.size() == 0) begin
					report($sformatf("response with no request pending: verdict %0d mask %0h",
						verdict, mask_out));
				end else begin
					want = class_q.pop_front();
					if (verdict !== want.verdict)
						report($sformatf("response %0d verdict %0d, expected %0d",
							n_checked, verdict, want.verdict));
					if (mask_out !== want.mask)
						report($sformatf("response %0d mask_out %0h, expected %0h",
							n_checked, mask_out, want.mask));
					if (start_out !== want.start)
						report($sformatf("response %0d start_out %0d, expected %0d",
							n_checked, start_out, want.start));
					n_verd[want.verdict]++;
					n_checked++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !((in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)))
			stall_cycles <= stall_cycles + 1;
		else
			stall_cycles <= 0;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("no handshake for %0d cycles, %0d of %0d responses seen",
				stall_cycles, n_checked, n_queued);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PLANE_LEFT;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_fire   = 1'b0;
		out_ready = 1'b0;
		min_x     = '0;
		min_y     = '0;
		min_z     = '0;
		max_x     = '0;
		max_y     = '0;
		max_z     = '0;
		mask_in   = '0;
		start_in  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// planes at reset value
		@(posedge clk);
		queue_random(60);
		wait_idle();

		fill_frustum(1000, 0);
		load_planes();
		queue_directed();
		queue_random(170);
		wait_idle();

		fill_frustum(200 + $urandom_range(2800), 3000);
		load_planes();
		send_idle_pct = 74;
		queue_random(200);
		wait_idle();

		// most negative normals with largest offset, and the reverse
		for (int i = 0; i < NUM_PLANES; i++)
			cfg_next[i] = (i < 3) ? 64'h7FFF_8000_8000_8000 : 64'h8000_7FFF_7FFF_7FFF;
		load_planes();
		send_idle_pct  = 0;
		recv_stall_pct = 74;
		queue_random(180);
		wait_idle();

		for (int i = 0; i < NUM_PLANES; i++)
			cfg_next[i] = {$urandom, $urandom};
		load_planes();
		send_idle_pct  = 13;
		recv_stall_pct = 13;
		queue_random(200);
		wait_idle();

		for (int i = 0; i < NUM_PLANES; i++)
			cfg_next[i] = '1;
		load_planes();
		queue_random(100);
		wait_idle();

		fill_frustum(1500, 8000);
		load_planes();
		send_idle_pct  = 0;
		recv_stall_pct = 74;
		queue_random(120);
		wait_idle();
		repeat (2 * PIPE_LAT) @(posedge clk);

		$display("%0d box requests checked across %0d plane settings plus reset values",
			n_checked, n_settings);
		$display("responses: %0d inside, %0d intersecting, %0d outside; %0d mismatches",
			n_verd[VERD_INSIDE], n_verd[VERD_ISECT], n_verd[VERD_OUTSIDE], n_errors);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/afc_pkg.sv
rtl/afc_cell.sv
rtl/afc_resolve.sv
rtl/aabb_frustum_classify.sv
test/tb_aabb_frustum_classify.sv
